FILE: rtl/lkvc_pkg.sv
// Package for the LRU key/value cache: field widths, operation codes,
// payload structs and the controller-to-datapath command and status structs.
// Depends on nothing.
package lkvc_pkg;

   localparam int CAP_W = 5;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Data returned by a get that misses (all ones, that is -1).
   localparam logic signed [VAL_W-1:0] MISS_DATA = '1;

   // Operation codes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // One request beat.
   typedef struct packed {
      logic                    op;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] data;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_get;
      logic out_blocked;
   } status_type;

endpackage

FILE: rtl/lkvc_ctrl.sv
// Controller of the LRU key/value cache: a two-state machine that captures a
// request, then commits it to the table; a get commits once the response register can take it.
// Depends on lkvc_pkg.
module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Handshakes are only open while no request is in flight. A register write
   // takes precedence over a request beat in the same cycle.
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;

   // Commands to the datapath.
   always_comb begin
      cmd.clear   = csr_valid && csr_ready;
      cmd.capture = req_valid && req_ready;
      cmd.commit  = (state_ff == ST_UPDATE) && !(status.is_get && status.out_blocked);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/lkvc_dpath.sv
// Datapath of the LRU key/value cache: the entry table with keys, values and
// recency ranks, the parallel key compare, the capacity register and the
// response register. Depends on lkvc_pkg.
module lkvc_dpath
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  req_type          req_data,
   input  logic [CAP_W-1:0] csr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   // Table storage. Keys, values and ranks are only meaningful where valid.
   logic [ENTRIES-1:0]      valid_ff;
   logic [ENTRIES-1:0]      valid_in;
   logic [KEY_W-1:0]        key_ff   [ENTRIES];
   logic [KEY_W-1:0]        key_in   [ENTRIES];
   logic [VAL_W-1:0]        value_ff [ENTRIES];
   logic [VAL_W-1:0]        value_in [ENTRIES];
   logic [RANK_W-1:0]       rank_ff  [ENTRIES];
   logic [RANK_W-1:0]       rank_in  [ENTRIES];
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [CAP_W-1:0]        capacity_ff;

   // Captured request and its match vector.
   req_type                 req_ff;
   logic [ENTRIES-1:0]      match_ff;
   logic [ENTRIES-1:0]      match_in;

   // Response register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   // Derived values for the update.
   logic [CNT_W-1:0]        eff_cap;
   logic                    hit;
   logic [VAL_W-1:0]        hit_value;
   logic [RANK_W-1:0]       hit_rank;
   logic [RANK_W-1:0]       lru_rank;
   logic [ENTRIES-1:0]      evict_vec;
   logic [ENTRIES-1:0]      free_vec;
   logic [ENTRIES-1:0]      target_vec;
   logic                    need_evict;

   // Compare the incoming key against every valid entry.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == req_data.key);
      end
   end

   // Capacity saturates at the table size.
   assign eff_cap = (32'(capacity_ff) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(capacity_ff);

   // At most one entry matches, so an AND-OR picks its value and rank.
   always_comb begin
      hit_value = '0;
      hit_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_ff[i]) begin
            hit_value = hit_value | value_ff[i];
            hit_rank  = hit_rank | rank_ff[i];
         end
      end
   end

   assign hit = |match_ff;

   // The victim holds the oldest rank; the free slot is the lowest invalid one.
   assign lru_rank   = RANK_W'(count_ff - 1'b1);
   assign need_evict = (count_ff >= eff_cap);
   assign free_vec   = ~valid_ff & (valid_ff + 1'b1);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         evict_vec[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
      end
   end

   assign target_vec = need_evict ? evict_vec : free_vec;

   // Next state of the table and the response register.
   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
      end

      if (cmd.clear) begin
         valid_in = '0;
         count_in = '0;
      end else if (cmd.commit) begin
         if (hit) begin
            // Promote the hit entry; entries more recent than it age by one.
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
               if (match_ff[i]) begin
                  rank_in[i] = '0;
                  if (req_ff.op == OP_PUT) begin
                     value_in[i] = req_ff.value;
                  end
               end
            end
            if (req_ff.op == OP_GET) begin
               rsp_valid_in = 1'b1;
               rsp_in.hit   = 1'b1;
               rsp_in.data  = hit_value;
            end
         end else if (req_ff.op == OP_GET) begin
            rsp_valid_in = 1'b1;
            rsp_in.hit   = 1'b0;
            rsp_in.data  = MISS_DATA;
         end else if (eff_cap != '0) begin
            // Insert as most recent, replacing the oldest entry when full.
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
               if (target_vec[i]) begin
                  valid_in[i] = 1'b1;
                  key_in[i]   = req_ff.key;
                  value_in[i] = req_ff.value;
                  rank_in[i]  = '0;
               end
            end
            if (!need_evict) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear) begin
            capacity_ff <= csr_data;
         end
      end
   end

   // Payload state.
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
         rank_ff[i]  <= rank_in[i];
      end
      rsp_ff <= rsp_in;
      if (cmd.capture) begin
         req_ff   <= req_data;
         match_ff <= match_in;
      end
   end

   assign status.is_get      = (req_ff.op == OP_GET);
   assign status.out_blocked = rsp_valid_ff && !rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

endmodule

FILE: rtl/lru_key_value_cache.sv
// Response: a get's response beat enters the response register when the get commits.
// Sequencing: the parallel key compare into the match register at capture, then the
// rank and table update at commit; no new request is taken before the last one commits; a full response
// register holds a get in its update state until the response beat leaves.
// Reset: synchronous; empties the table and sets the capacity to 16.
// Top level of the LRU key/value cache. Depends on lkvc_pkg, lkvc_ctrl, lkvc_dpath.
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencing of capture and commit.
   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Entry table and response register.
   lkvc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
